@@ hw/rtl/fps_pkg.sv @@
// ----------------------------------------------------------------------------
// fps_pkg: types and constants of the flash program sequencer
// Transaction payloads, burst descriptor, opcodes, result kinds and the
// fixed unlock addresses and command bytes of the program sequence.
// ----------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

  localparam int unsigned BankW   = 3;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned AddrW   = BankW + OffsetW;
  localparam int unsigned LimitW  = 16;

  // Input opcodes
  localparam logic [1:0] OP_PROGRAM  = 2'd0;
  localparam logic [1:0] OP_READBACK = 2'd1;
  localparam logic [1:0] OP_RESTART  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_WRITE      = 3'd0;
  localparam logic [2:0] KIND_READ       = 3'd1;
  localparam logic [2:0] KIND_PROGRAMMED = 3'd2;
  localparam logic [2:0] KIND_SKIPPED    = 3'd3;
  localparam logic [2:0] KIND_FAILED     = 3'd4;
  localparam logic [2:0] KIND_IGNORED    = 3'd5;

  // Unlock / program command sequence
  localparam logic [OffsetW-1:0] UNLOCK_ADDR_A = 16'h5555;
  localparam logic [OffsetW-1:0] UNLOCK_ADDR_B = 16'h2AAA;
  localparam logic [7:0]         UNLOCK_DATA_A = 8'hAA;
  localparam logic [7:0]         UNLOCK_DATA_B = 8'h55;
  localparam logic [7:0]         PROGRAM_CMD   = 8'hA0;

  localparam logic [LimitW-1:0]  POLL_LIMIT_RESET = 16'd60000;
  localparam logic [LimitW-1:0]  POLL_COUNT_MAX   = 16'hFFFF;

  // Beats of a program burst
  localparam logic [2:0] BEAT_UNLOCK_A = 3'd0;
  localparam logic [2:0] BEAT_UNLOCK_B = 3'd1;
  localparam logic [2:0] BEAT_COMMAND  = 3'd2;
  localparam logic [2:0] BEAT_DATA     = 3'd3;
  localparam logic [2:0] BEAT_READ     = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] bus_addr;
    logic [7:0]       bus_data;
    logic [2:0]       kind;
    logic             last;
  } out_item_t;

  // One burst of results caused by a single input transaction
  typedef struct packed {
    logic             load;     // a burst is produced
    logic             prog;     // five-beat program burst, else one status beat
    logic [AddrW-1:0] addr;     // bank:offset of the byte concerned
    logic [7:0]       data;     // byte to program
    logic [2:0]       kind;     // kind of a single status beat
  } burst_t;

endpackage

`default_nettype wire

@@ hw/rtl/flash_program_sequencer.sv @@
// ----------------------------------------------------------------------------
// flash_program_sequencer: byte program sequencer for a banked parallel flash
// Turns program and read-back transactions into unlock, command, data and
// read request bus cycles plus status results, tracking bank:offset.
// ----------------------------------------------------------------------------
//
//   channel  | signals                          | carries
//   ---------+----------------------------------+----------------------------
//   in       | in_valid, in_stall, in_item      | opcode, data
//   out      | out_valid, out_stall, out_item   | bus_addr, bus_data, kind, last
//   config   | cfg_write, cfg_data              | poll_limit
//
// A program transaction at an unprotected byte, with no read-back awaited,
// yields five result transactions, one per cycle while out_stall is low;
// all other transactions yield one (a restart yields none). The result
// emitter's beat counter sets the pace, one beat per accepted result.
// A new input transaction is taken in the cycle the previous burst's last
// beat leaves, so bursts follow back to back.
// Reset (rst, synchronous) clears position, poll state and any pending
// burst, and sets poll_limit to 60000.
// Output stall holds the current beat; input stall is raised only while a
// burst is pending that cannot finish in the current cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_program_sequencer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fps_pkg::in_item_t in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fps_pkg::out_item_t out_item,
  input  wire logic          cfg_write,
  input  wire logic [15:0]   cfg_data
);
  import fps_pkg::*;

  burst_t burst;
  logic   free;
  logic   take;

  // Take a transaction whenever the emitter can accept the burst it causes
  assign in_stall = !free;
  assign take     = in_valid && free;

  // Decode against position and poll state, update the state
  fps_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .burst     (burst)
  );

  // Play the burst out on the result channel
  fps_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .free      (free)
  );

endmodule

`default_nettype wire

@@ hw/rtl/fps_core.sv @@
// ----------------------------------------------------------------------------
// fps_core: position and poll state of the flash program sequencer
// Decodes one input transaction against the current state, updates the
// state and hands a burst descriptor to the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire fps_pkg::in_item_t item,
  input  wire logic             cfg_write,
  input  wire logic [15:0]      cfg_data,
  output fps_pkg::burst_t       burst
);
  import fps_pkg::*;

  logic [AddrW-1:0]  pos;            // bank:offset
  logic              awaiting;
  logic [7:0]        expected_byte;
  logic [LimitW-1:0] poll_count;
  logic [LimitW-1:0] poll_limit;

  logic [AddrW-1:0]  pos_next;
  logic              awaiting_next;
  logic [7:0]        expected_next;
  logic [LimitW-1:0] poll_count_next;
  logic [LimitW-1:0] poll_bumped;
  logic [LimitW-1:0] limit_eff;
  logic              protected_pos;

  assign protected_pos = (pos[AddrW-1 -: BankW] == '0) && pos[OffsetW-1];
  assign poll_bumped   = (poll_count == POLL_COUNT_MAX) ? poll_count
                                                        : poll_count + 1'b1;
  assign limit_eff     = (poll_limit == '0) ? LimitW'(1) : poll_limit;

  always_comb begin
    pos_next        = pos;
    awaiting_next   = awaiting;
    expected_next   = expected_byte;
    poll_count_next = poll_count;
    burst.load      = 1'b1;
    burst.prog      = 1'b0;
    burst.addr      = pos;
    burst.data      = '0;
    burst.kind      = KIND_IGNORED;
    if (item.opcode == OP_RESTART) begin
      pos_next        = '0;
      awaiting_next   = 1'b0;
      expected_next   = '0;
      poll_count_next = '0;
      burst.load      = 1'b0;
    end else if (item.opcode == OP_PROGRAM && !awaiting) begin
      if (protected_pos) begin
        burst.kind = KIND_SKIPPED;
        pos_next   = pos + 1'b1;
      end else begin
        burst.prog      = 1'b1;
        burst.data      = item.data;
        burst.kind      = KIND_WRITE;
        awaiting_next   = 1'b1;
        expected_next   = item.data;
        poll_count_next = '0;
      end
    end else if (item.opcode == OP_READBACK && awaiting) begin
      poll_count_next = poll_bumped;
      if (item.data == expected_byte) begin
        burst.kind    = KIND_PROGRAMMED;
        awaiting_next = 1'b0;
        pos_next      = pos + 1'b1;
      end else if (poll_bumped >= limit_eff) begin
        burst.kind    = KIND_FAILED;
        awaiting_next = 1'b0;
      end else begin
        burst.kind = KIND_READ;
      end
    end
    if (!take) begin
      burst.load = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      awaiting      <= 1'b0;
      expected_byte <= '0;
      poll_count    <= '0;
      poll_limit    <= POLL_LIMIT_RESET;
    end else begin
      if (take) begin
        pos           <= pos_next;
        awaiting      <= awaiting_next;
        expected_byte <= expected_next;
        poll_count    <= poll_count_next;
      end
      if (cfg_write) begin
        poll_limit <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fps_emit.sv @@
// ----------------------------------------------------------------------------
// fps_emit: result emitter of the flash program sequencer
// Holds one burst descriptor and plays it out beat by beat on the output
// channel, one result transaction per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_emit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire fps_pkg::burst_t burst,
  input  wire logic         out_stall,
  output logic              out_valid,
  output fps_pkg::out_item_t out_item,
  output logic              free
);
  import fps_pkg::*;

  logic       busy;
  burst_t     held;
  logic [2:0] beat;
  logic       last_beat;
  logic       beat_done;

  assign last_beat = !held.prog || (beat == BEAT_READ);
  assign beat_done = busy && !out_stall;
  // Free for a new burst when empty or when the final beat leaves now
  assign free      = !busy || (beat_done && last_beat);
  assign out_valid = busy;

  always_comb begin
    out_item.bus_addr = held.addr;
    out_item.bus_data = '0;
    out_item.kind     = held.kind;
    out_item.last     = last_beat;
    if (held.prog) begin
      case (beat)
        BEAT_UNLOCK_A: begin
          out_item.bus_addr = {held.addr[AddrW-1 -: BankW], UNLOCK_ADDR_A};
          out_item.bus_data = UNLOCK_DATA_A;
          out_item.kind     = KIND_WRITE;
        end
        BEAT_UNLOCK_B: begin
          out_item.bus_addr = {held.addr[AddrW-1 -: BankW], UNLOCK_ADDR_B};
          out_item.bus_data = UNLOCK_DATA_B;
          out_item.kind     = KIND_WRITE;
        end
        BEAT_COMMAND: begin
          out_item.bus_addr = {held.addr[AddrW-1 -: BankW], UNLOCK_ADDR_A};
          out_item.bus_data = PROGRAM_CMD;
          out_item.kind     = KIND_WRITE;
        end
        BEAT_DATA: begin
          out_item.bus_data = held.data;
          out_item.kind     = KIND_WRITE;
        end
        default: begin
          out_item.kind = KIND_READ;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (free) begin
      busy <= burst.load;
      beat <= '0;
    end else if (beat_done) begin
      beat <= beat + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (free && burst.load) begin
      held <= burst;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fps_checker.sv @@
// ----------------------------------------------------------------------------
// fps_checker: port-level checks for the flash program sequencer
// Watches the handshakes and result framing at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fps_pkg::out_item_t out_item
);
  import fps_pkg::*;

  // Input is only held off while results are pending
  a_stall_needs_results: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A burst is never broken before its last result
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_item.last) |=> out_valid)
    else $error("result burst broken before last");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result stays offered
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

endmodule

bind flash_program_sequencer fps_checker u_fps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the flash program sequencer
// Drives program, read-back, restart and unused-opcode transactions with
// random gaps. Drives output stall in random bursts. Keeps a bank:offset and
// poll-state shadow of the sequencer that forecasts every bus cycle and
// status result, and compares each result transaction with that forecast,
// field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import fps_pkg::*;

  // Opcode value the sequencer has no use for; it must be reported as ignored
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  // Offsets at and above this one are protected in bank 0
  localparam logic [15:0] PROTECT_START = 16'h8000;
  // Quiet cycles (nothing accepted on either channel) before giving up
  localparam int unsigned QUIET_LIMIT   = 1000;
  // Cycles to let pass after the last forecast result before touching config
  localparam int unsigned SETTLE_CYCLES = 12;
  // Cap on printed mismatch lines; further mismatches are still counted
  localparam int unsigned REPORT_CAP    = 50;
  // Consecutive bytes programmed by the position walk
  localparam int unsigned WALK_BYTES    = 12;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data  = '0;

  flash_program_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the sequencer: write position, poll state and the poll limit
  // --------------------------------------------------------------------------
  logic [2:0]  pos_bank   = '0;
  logic [15:0] pos_offset = '0;
  logic        await_rb   = 1'b0;
  logic [7:0]  prog_byte  = '0;
  logic [15:0] poll_cnt   = '0;
  logic [15:0] poll_limit = POLL_LIMIT_RESET;

  // Bus cycles and status results forecast but not yet seen, oldest first
  out_item_t   pending_beats[$];

  bit          idle_on = 1'b1;
  int          errors  = 0;
  int unsigned n_sent, n_checked, n_programmed, n_failed, n_skipped, n_ignored;
  int unsigned stall_left = 0;
  int unsigned quiet      = 0;

  task automatic push_beat(input logic [15:0] low16, input logic [7:0] d,
                           input logic [2:0] k, input logic l);
    out_item_t b;
    b.bus_addr = {pos_bank, low16};
    b.bus_data = d;
    b.kind     = k;
    b.last     = l;
    pending_beats.push_back(b);
  endtask

  // Advance bank:offset; the offset carries into the bank, which wraps at 8
  task automatic advance_position();
    pos_offset = pos_offset + 16'd1;
    if (pos_offset == 16'd0) begin
      pos_bank = pos_bank + 3'd1;
    end
  endtask

  // Forecast the results of one accepted transaction and update the shadow
  task automatic forecast_beats(input in_item_t it);
    logic [15:0] lim;
    lim = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
    if (it.opcode == OP_RESTART) begin
      // Restart: clear everything, emit nothing
      pos_bank   = '0;
      pos_offset = '0;
      await_rb   = 1'b0;
      prog_byte  = '0;
      poll_cnt   = '0;
    end else if (it.opcode == OP_PROGRAM && !await_rb) begin
      if (pos_bank == 3'd0 && pos_offset >= PROTECT_START) begin
        // Protected upper half of bank 0: skip but still move on
        push_beat(pos_offset, 8'h00, KIND_SKIPPED, 1'b1);
        advance_position();
        n_skipped++;
      end else begin
        push_beat(UNLOCK_ADDR_A, UNLOCK_DATA_A, KIND_WRITE, 1'b0);
        push_beat(UNLOCK_ADDR_B, UNLOCK_DATA_B, KIND_WRITE, 1'b0);
        push_beat(UNLOCK_ADDR_A, PROGRAM_CMD, KIND_WRITE, 1'b0);
        push_beat(pos_offset, it.data, KIND_WRITE, 1'b0);
        push_beat(pos_offset, 8'h00, KIND_READ, 1'b1);
        await_rb  = 1'b1;
        prog_byte = it.data;
        poll_cnt  = '0;
      end
    end else if (it.opcode == OP_READBACK && await_rb) begin
      if (poll_cnt != POLL_COUNT_MAX) begin
        poll_cnt = poll_cnt + 16'd1;
      end
      if (it.data == prog_byte) begin
        push_beat(pos_offset, 8'h00, KIND_PROGRAMMED, 1'b1);
        await_rb = 1'b0;
        advance_position();
        n_programmed++;
      end else if (poll_cnt >= lim) begin
        // Out of attempts: report failure and hold the position
        push_beat(pos_offset, 8'h00, KIND_FAILED, 1'b1);
        await_rb = 1'b0;
        n_failed++;
      end else begin
        push_beat(pos_offset, 8'h00, KIND_READ, 1'b1);
      end
    end else begin
      push_beat(pos_offset, 8'h00, KIND_IGNORED, 1'b1);
      n_ignored++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side: offer one transaction, hold it until taken, then maybe idle
  // --------------------------------------------------------------------------
  task automatic send_txn(input logic [1:0] op, input logic [7:0] d);
    in_item_t    it;
    int unsigned gap;
    it.opcode = op;
    it.data   = d;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    forecast_beats(it);
    n_sent++;
    // Valid stays high when the next transaction follows straight on
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every forecast result has arrived, then
  // let the sequencer settle (a restart leaves nothing to wait for)
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the poll limit while the sequencer is idle
  task automatic set_poll_limit(input logic [15:0] v);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    poll_limit = v;
  endtask

  // --------------------------------------------------------------------------
  // Output side: check each accepted result, stall in random bursts
  // --------------------------------------------------------------------------
  task automatic report_field(input string f, input logic [31:0] want,
                              input logic [31:0] got);
    errors++;
    if (errors <= REPORT_CAP) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, f, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual addr %0h data %0h kind %0d last %0b",
                   $time, out_item.bus_addr, out_item.bus_data, out_item.kind, out_item.last);
        end else begin
          want = pending_beats.pop_front();
          n_checked++;
          if (out_item.bus_addr !== want.bus_addr)
            report_field("bus_addr", 32'(want.bus_addr), 32'(out_item.bus_addr));
          if (out_item.bus_data !== want.bus_data)
            report_field("bus_data", 32'(want.bus_data), 32'(out_item.bus_data));
          if (out_item.kind !== want.kind)
            report_field("kind", 32'(want.kind), 32'(out_item.kind));
          if (out_item.last !== want.last)
            report_field("last", 32'(want.last), 32'(out_item.last));
        end
      end
      // Stall in bursts of random length; a new burst never starts while out_stall is still high
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idle_on && !out_stall && $urandom_range(0, 4) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 11);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Program the extreme bytes; one read-back miss under the reset poll limit
  task automatic test_program_basic();
    send_txn(OP_PROGRAM, 8'h00);
    send_txn(OP_READBACK, 8'h00);
    send_txn(OP_PROGRAM, 8'hFF);
    send_txn(OP_READBACK, 8'h7F);
    send_txn(OP_READBACK, 8'hFF);
  endtask

  // Read-back with nothing pending, program while waiting, unused opcode
  task automatic test_ignored_transactions();
    send_txn(OP_READBACK, 8'h5A);
    send_txn(OP_UNUSED, 8'hC3);
    send_txn(OP_PROGRAM, 8'h81);
    send_txn(OP_PROGRAM, 8'h18);
    send_txn(OP_UNUSED, 8'h00);
    send_txn(OP_READBACK, 8'h81);
  endtask

  // Restart in the middle of a poll, then again while idle
  task automatic test_restart();
    send_txn(OP_PROGRAM, 8'h3C);
    send_txn(OP_RESTART, 8'hFF);
    send_txn(OP_READBACK, 8'h3C);
    send_txn(OP_PROGRAM, 8'hC3);
    send_txn(OP_READBACK, 8'hC3);
    send_txn(OP_RESTART, 8'h00);
    drain_results();
  endtask

  // Failure at the smallest limits, a limit of zero, and the largest limit
  task automatic test_poll_limits();
    set_poll_limit(16'd1);
    send_txn(OP_PROGRAM, 8'hAA);
    send_txn(OP_READBACK, 8'h55);
    set_poll_limit(16'd0);
    send_txn(OP_PROGRAM, 8'h01);
    send_txn(OP_READBACK, 8'h02);
    set_poll_limit(16'd3);
    send_txn(OP_PROGRAM, 8'h80);
    send_txn(OP_READBACK, 8'h00);
    send_txn(OP_READBACK, 8'h00);
    send_txn(OP_READBACK, 8'h00);
    set_poll_limit(16'hFFFF);
    send_txn(OP_PROGRAM, 8'h7E);
    send_txn(OP_READBACK, 8'h00);
    send_txn(OP_READBACK, 8'h7E);
  endtask

  // Restart, then program a run of consecutive bytes flat out, each
  // verified on its first read-back, so the offset steps up one at a time
  task automatic test_bank_walk();
    logic [7:0] d;
    set_poll_limit(16'd4);
    idle_on = 1'b0;
    send_txn(OP_RESTART, 8'h00);
    repeat (WALK_BYTES) begin
      d = 8'($urandom);
      send_txn(OP_PROGRAM, d);
      send_txn(OP_READBACK, d);
    end
    drain_results();
    idle_on = 1'b1;
  endtask

  // Mostly well-formed program/poll sequences with random bytes; the rest is
  // noise: unused opcodes, out-of-turn transactions and the odd restart
  task automatic test_random_traffic(input logic [15:0] lim, input int unsigned n);
    int unsigned done;
    int unsigned r;
    logic [7:0]  d;
    set_poll_limit(lim);
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        if (await_rb) begin
          d = ($urandom_range(0, 2) == 0) ? prog_byte : 8'($urandom);
          send_txn(OP_READBACK, d);
        end else begin
          send_txn(OP_PROGRAM, 8'($urandom));
        end
        done++;
      end else if (r < 86) begin
        send_txn(OP_RESTART, 8'($urandom));
        done++;
      end else if (r < 92) begin
        send_txn(OP_UNUSED, 8'($urandom));
      end else begin
        send_txn(await_rb ? OP_PROGRAM : OP_READBACK, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_program_basic();
    test_ignored_transactions();
    test_restart();
    test_poll_limits();

    test_random_traffic(16'd2, 80);
    test_bank_walk();
    test_random_traffic(16'hFFFF, 70);
    test_random_traffic(16'd1, 60);
    test_random_traffic(16'd5, 60);
    // Last stretch runs flat out on both sides
    idle_on = 1'b0;
    test_random_traffic(16'd3, 70);

    drain_results();
    $display("Sent %0d transactions and checked %0d results: %0d programmed, %0d failed,",
             n_sent, n_checked, n_programmed, n_failed);
    $display("%0d skipped, %0d ignored; a back-to-back walk stepped the offset byte by byte.",
             n_skipped, n_ignored);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
